// ----- rtl/bmhq_pkg.sv -----
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int TAG_WIDTH = 10;

  // Slot s (1..CAPACITY) lives at RAM address s-1.
  localparam int ADDR_W = $clog2(CAPACITY);
  // Counts and slot numbers reach CAPACITY itself.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // Child slots reach 2*CAPACITY+1.
  localparam int POS_W  = CNT_W + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [POS_W-1:0] slot);
    logic [POS_W-1:0] idx;
    idx = slot - POS_W'(1);
    return idx[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/bmhq_ram.sv -----
`timescale 1ns / 1ps

// One write port, two registered read ports.
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
`timescale 1ns / 1ps

// Binary min-heap priority queue of (key, tag) entries.
// Input channel (in_valid_i/in_ready_o): one word per operation; operation_i
// selects push (key_i, tag_i appended and sifted up) or pop (root removed,
// last entry moved to the root and sifted down). Key and tag are ignored on pop.
// Output channel (out_valid_o/out_ready_i): exactly one word per operation with
// the popped entry (zero otherwise), a status code and the occupancy after it.
// A push reads and compares each parent in turn; a pop reads the root and the
// last entry, then reads and compares the children of each slot in turn.
// Pop on empty and push on full go straight to the output state without
// touching the heap RAM. in_ready_o rises with out_valid_o.
// One operation is in flight at a time; the moving entry is held in a register
// and written only where it comes to rest, so no access overlaps an earlier one.
// The output register lets the next word be accepted while a result waits;
// if the receiver still stalls when that next result is ready, the block holds
// in its output state and in_ready_o stays low.
// Reset clears the entry count and the handshake state; the heap RAM is not
// cleared, since only occupied slots are ever read.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [TAG_WIDTH-1:0] tag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [KEY_WIDTH-1:0] out_key_o,
  output logic [TAG_WIDTH-1:0] out_tag_o,
  output logic [1:0]           status_o,
  output logic [CNT_W-1:0]     occupancy_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_POP_RD = 8'b0000_1000,
    S_POP_LD = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;   // occupied slots
  logic [CNT_W-1:0] pos_q, pos_d;       // slot of the hole being sifted
  entry_t           carry_q, carry_d;   // entry travelling through the heap
  entry_t           res_q, res_d;       // popped entry for the result word
  status_e          res_st_q, res_st_d;

  logic             out_valid_q, out_valid_d;
  entry_t           out_q, out_d;
  status_e          out_st_q, out_st_d;
  logic [CNT_W-1:0] occ_q, occ_d;

  // heap RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a, ram_raddr_b;
  logic [ENTRY_W-1:0] ram_rdata_a, ram_rdata_b;
  entry_t            rd_a, rd_b;

  bmhq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  assign rd_a = entry_t'(ram_rdata_a);
  assign rd_b = entry_t'(ram_rdata_b);

  // slot arithmetic
  logic [POS_W-1:0] pos_w, count_w, left_w, right_w, parent_w;
  logic             right_ok, pick_right;
  entry_t           pick;
  logic [POS_W-1:0] pick_slot;
  logic             out_free;

  assign pos_w    = {1'b0, pos_q};
  assign count_w  = {1'b0, count_q};
  assign left_w   = {pos_q, 1'b0};
  assign right_w  = {pos_q, 1'b1};
  assign parent_w = {2'b00, pos_q[CNT_W-1:1]};

  // Right child wins only when strictly smaller; ties go left.
  assign right_ok   = (right_w <= count_w);
  assign pick_right = right_ok && (rd_a.key > rd_b.key);
  assign pick       = pick_right ? rd_b : rd_a;
  assign pick_slot  = pick_right ? right_w : left_w;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    res_d       = res_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_st_d    = out_st_q;
    occ_d       = occ_q;

    ram_we      = 1'b0;
    ram_waddr   = slot_addr(pos_w);
    ram_wdata   = carry_q;
    ram_raddr_a = slot_addr(parent_w);
    ram_raddr_b = slot_addr(count_w);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d    = '0;
          res_st_d = ST_DONE;
          if (operation_i == OP_PUSH) begin
            if (count_w >= POS_W'(CAPACITY)) begin
              res_st_d = ST_FULL;
              state_d  = S_OUT;
            end else begin
              count_d     = count_q + CNT_W'(1);
              pos_d       = count_q + CNT_W'(1);
              carry_d.key = key_i;
              carry_d.tag = tag_i;
              state_d     = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              state_d = S_POP_RD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == CNT_W'(1)) begin
          ram_we  = 1'b1;
          state_d = S_OUT;
        end else begin
          ram_raddr_a = slot_addr(parent_w);
          state_d     = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        // Rise past parents whose key is greater or equal.
        ram_we = 1'b1;
        if (carry_q.key > rd_a.key) begin
          state_d = S_OUT;
        end else begin
          ram_wdata = rd_a;
          pos_d     = parent_w[CNT_W-1:0];
          state_d   = S_UP_RD;
        end
      end

      S_POP_RD: begin
        ram_raddr_a = slot_addr(POS_W'(1));
        ram_raddr_b = slot_addr(count_w);
        state_d     = S_POP_LD;
      end

      S_POP_LD: begin
        res_d   = rd_a;
        carry_d = rd_b;
        count_d = count_q - CNT_W'(1);
        pos_d   = CNT_W'(1);
        // Last entry gone with the root: nothing to place.
        state_d = (count_q == CNT_W'(1)) ? S_OUT : S_DN_RD;
      end

      S_DN_RD: begin
        if (left_w > count_w) begin
          ram_we  = 1'b1;
          state_d = S_OUT;
        end else begin
          ram_raddr_a = slot_addr(left_w);
          ram_raddr_b = slot_addr(right_w);
          state_d     = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        // Sink only below a strictly smaller child.
        ram_we = 1'b1;
        if (carry_q.key > pick.key) begin
          ram_wdata = pick;
          pos_d     = pick_slot[CNT_W-1:0];
          state_d   = S_DN_RD;
        end else begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_st_d    = res_st_q;
          occ_d       = count_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    carry_q  <= carry_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    out_q    <= out_d;
    out_st_q <= out_st_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_q.key;
  assign out_tag_o   = out_q.tag;
  assign status_o    = out_st_q;
  assign occupancy_o = occ_q;

endmodule

// ----- dv/tb_binary_min_heap_queue.sv -----
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  // The long receiver hold-off is HOLD_CYCLES.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 7;
  localparam int SEG_ITEMS    = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP    = 100;
  localparam logic [KEY_WIDTH-1:0] KEY_MAX = '1;
  // Push share (percent) per random segment: shallow, deep and draining heaps.
  localparam int PUSH_MIX [SEGMENTS] = '{90, 50, 70, 30, 90, 60, 40};

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
    status_e              status;
    logic [CNT_W-1:0]     occupancy;
  } pop_result_t;

  // Mirror of the heap: same sift rules as the block, one result word per op.
  class heap_scoreboard;
    entry_t      slots [1:CAPACITY];
    int          count;
    pop_result_t expected [$];
    int          mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void swap_slots(int a, int b);
      entry_t t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    // Rises past parents with an equal key.
    function void sift_up(int pos);
      int up;
      while (pos > 1) begin
        up = pos / 2;
        if (slots[pos].key > slots[up].key) break;
        swap_slots(pos, up);
        pos = up;
      end
    endfunction

    // Left child wins a tie; stops at a child with an equal key.
    function void sift_down(int pos);
      int left;
      int pick;
      forever begin
        left = 2 * pos;
        if (left > count) break;
        pick = left;
        if (left + 1 <= count && slots[left].key > slots[left + 1].key) pick = left + 1;
        if (!(slots[pos].key > slots[pick].key)) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    endfunction

    function void note_input(logic op, logic [KEY_WIDTH-1:0] key, logic [TAG_WIDTH-1:0] tag);
      pop_result_t r;
      r.key    = '0;
      r.tag    = '0;
      r.status = ST_DONE;
      if (op == OP_PUSH) begin
        if (count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          count++;
          slots[count].key = key;
          slots[count].tag = tag;
          sift_up(count);
        end
      end else if (count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key    = slots[1].key;
        r.tag    = slots[1].tag;
        slots[1] = slots[count];
        count--;
        sift_down(1);
      end
      r.occupancy = CNT_W'(count);
      expected.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(logic [KEY_WIDTH-1:0] key, logic [TAG_WIDTH-1:0] tag,
                      logic [1:0] status, logic [CNT_W-1:0] occupancy);
      pop_result_t want;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending key=%h tag=%h", key, tag));
        return;
      end
      want = expected.pop_front();
      if (key !== want.key)
        report_mismatch($sformatf("out_key %h, want %h", key, want.key));
      if (tag !== want.tag)
        report_mismatch($sformatf("out_tag %h, want %h", tag, want.tag));
      if (status !== 2'(want.status))
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, want.occupancy));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 operation_i;
  logic [KEY_WIDTH-1:0] key_i;
  logic [TAG_WIDTH-1:0] tag_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [KEY_WIDTH-1:0] out_key_o;
  logic [TAG_WIDTH-1:0] out_tag_o;
  logic [1:0]           status_o;
  logic [CNT_W-1:0]     occupancy_o;

  heap_scoreboard sb = new();

  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off.
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  binary_min_heap_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_key_o   (out_key_o),
    .out_tag_o   (out_tag_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long gap.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Small keys give plenty of ties; extremes and full-range keys hit every bit.
  function automatic logic [KEY_WIDTH-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return KEY_WIDTH'($urandom_range(0, 15));
    if (roll < 45) return '0;
    if (roll < 50) return KEY_MAX;
    return KEY_WIDTH'({$urandom, $urandom});
  endfunction

  function automatic logic [TAG_WIDTH-1:0] pick_tag();
    return TAG_WIDTH'($urandom);
  endfunction

  // Offer one word at a falling edge and hold it until the rising edge that takes it.
  task automatic send_word(input logic op, input logic [KEY_WIDTH-1:0] key,
                           input logic [TAG_WIDTH-1:0] tag);
    int gap;
    gap = calm ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    tag_i       <= tag;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic push_word(input logic [KEY_WIDTH-1:0] key, input logic [TAG_WIDTH-1:0] tag);
    send_word(OP_PUSH, key, tag);
  endtask

  // Key and tag are don't-care on a pop, so they carry noise.
  task automatic pop_word();
    send_word(OP_POP, pick_key(), pick_tag());
  endtask

  // Sender goes quiet until every pending word has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready bursts and gaps, a steady ready when calm,
  // and one long hold-off on request so the block backs up into its input.
  initial begin : receiver
    int run_len;
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end else if (calm) begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) begin
          @(negedge clk_i);
          out_ready_i <= 1'b1;
        end
        gap = idle_len();
        repeat (gap) begin
          @(negedge clk_i);
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // Both channels sampled at the rising edge; a word moves when valid and ready are high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(operation_i, key_i, tag_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(out_key_o, out_tag_o, status_o, occupancy_o);
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    int drain_count;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_PUSH;
    key_i       = '0;
    tag_i       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, key extremes, ties on the way up and down.
    pop_word();
    push_word('0, '0);
    push_word(KEY_MAX, '1);
    push_word(KEY_MAX, 10'h155);
    push_word('0, 10'h2AA);             // equal to root key: must rise to the top
    push_word(KEY_WIDTH'(5), 10'd1);
    push_word(KEY_WIDTH'(5), 10'd2);
    push_word(KEY_WIDTH'(5), 10'd3);
    repeat (7) pop_word();
    pop_word();                         // empty again
    push_word(KEY_WIDTH'(3), 10'd10);
    push_word(KEY_WIDTH'(9), 10'd11);
    push_word(KEY_WIDTH'(9), 10'd12);   // equal children, equal to the moved entry: it stays at the root
    push_word(KEY_WIDTH'(9), 10'd13);
    push_word(KEY_WIDTH'(9), 10'd14);
    repeat (5) pop_word();
    wait_drained();

    // Random segments with varying push shares; one without idling, and one
    // where the receiver holds off so the input stalls.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      calm = (seg == 2);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg == 4 && i == 10) hold_req = 1'b1;
        if ($urandom_range(0, 99) < PUSH_MIX[seg]) push_word(pick_key(), pick_tag());
        else pop_word();
      end
    end
    calm = 1'b0;
    wait_drained();

    // Drain past empty.
    drain_count = sb.count;
    repeat (drain_count + 2) pop_word();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_min_heap_queue.sv
dv/tb_binary_min_heap_queue.sv
